// File: hdl/wsfd_pkg.sv
// Shared types and constants for the WebSocket frame deframer.
package wsfd_pkg;

  localparam int LEN_W = 63;

  // parser phases, one-hot
  typedef enum logic [4:0] {
    PH_HDR0 = 5'b00001,
    PH_HDR1 = 5'b00010,
    PH_EXT  = 5'b00100,
    PH_KEY  = 5'b01000,
    PH_DATA = 5'b10000
  } phase_t;

  // result kind codes
  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_DATA   = 1'b1;

  // 7-bit length codes that select an extended length
  localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
  localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

  // header bytes still to come for each extended field
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;
  localparam logic [3:0] KEY_BYTES   = 4'd4;

  typedef struct packed {
    logic             kind;
    logic             final_flag;
    logic [2:0]       reserved_bits;
    logic [3:0]       frame_opcode;
    logic             masked;
    logic [LEN_W-1:0] payload_length;
    logic [7:0]       data_out;
    logic             end_of_frame;
  } result_t;

endpackage

// File: hdl/wsfd_parser.sv
// Frame header parser and payload unmasker: state plus one-byte next-state logic.
module wsfd_parser import wsfd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] rx_byte,
  output logic       res_valid,
  output result_t    res
);

  phase_t           phase, phase_next;
  logic [3:0]       cnt, cnt_next;
  logic             fin, fin_next;
  logic [2:0]       rsv, rsv_next;
  logic [3:0]       opc, opc_next;
  logic             mask, mask_next;
  logic [LEN_W-1:0] len, len_next;
  logic [31:0]      key, key_next;
  logic [LEN_W-1:0] remain, remain_next;
  logic [1:0]       pos, pos_next;

  logic       len_done;
  logic       hdr_done;
  logic [7:0] key_byte;
  logic       eof;

  always_comb begin
    phase_next  = phase;
    cnt_next    = cnt;
    fin_next    = fin;
    rsv_next    = rsv;
    opc_next    = opc;
    mask_next   = mask;
    len_next    = len;
    key_next    = key;
    remain_next = remain;
    pos_next    = pos;
    len_done    = 1'b0;
    hdr_done    = 1'b0;
    key_byte    = 8'd0;
    eof         = 1'b0;
    res_valid   = 1'b0;
    res.kind    = KIND_HEADER;
    res.data_out     = 8'd0;
    res.end_of_frame = 1'b0;

    unique case (phase)
      PH_HDR0: begin
        fin_next   = rx_byte[7];
        rsv_next   = rx_byte[6:4];
        opc_next   = rx_byte[3:0];
        phase_next = PH_HDR1;
      end
      PH_HDR1: begin
        mask_next = rx_byte[7];
        len_next  = '0;
        if (rx_byte[6:0] == LEN_CODE_EXT16) begin
          cnt_next   = EXT16_BYTES;
          phase_next = PH_EXT;
        end else if (rx_byte[6:0] == LEN_CODE_EXT64) begin
          cnt_next   = EXT64_BYTES;
          phase_next = PH_EXT;
        end else begin
          len_next = LEN_W'(rx_byte[6:0]);
          len_done = 1'b1;
        end
      end
      PH_EXT: begin
        // the top bit of a 64-bit length falls off the 63-bit register
        len_next = {len[LEN_W-9:0], rx_byte};
        cnt_next = cnt - 4'd1;
        len_done = (cnt == 4'd1);
      end
      PH_KEY: begin
        key_next = {key[23:0], rx_byte};
        cnt_next = cnt - 4'd1;
        hdr_done = (cnt == 4'd1);
      end
      PH_DATA: begin
        if (mask) begin
          unique case (pos)
            2'd0: key_byte = key[31:24];
            2'd1: key_byte = key[23:16];
            2'd2: key_byte = key[15:8];
            2'd3: key_byte = key[7:0];
          endcase
        end
        eof         = (remain == LEN_W'(1));
        remain_next = remain - LEN_W'(1);
        pos_next    = pos + 2'd1;
        res_valid   = 1'b1;
        res.kind    = KIND_DATA;
        res.data_out     = rx_byte ^ key_byte;
        res.end_of_frame = eof;
        if (eof) begin
          phase_next = PH_HDR0;
        end
      end
      default: begin
        phase_next = PH_HDR0;
      end
    endcase

    if (len_done) begin
      if (mask_next) begin
        cnt_next   = KEY_BYTES;
        phase_next = PH_KEY;
      end else begin
        hdr_done = 1'b1;
      end
    end

    if (hdr_done) begin
      remain_next      = len_next;
      pos_next         = 2'd0;
      res_valid        = 1'b1;
      res.end_of_frame = (len_next == '0);
      phase_next       = (len_next == '0) ? PH_HDR0 : PH_DATA;
    end

    res.final_flag     = fin_next;
    res.reserved_bits  = rsv_next;
    res.frame_opcode   = opc_next;
    res.masked         = mask_next;
    res.payload_length = len_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HDR0;
      cnt   <= 4'd0;
      pos   <= 2'd0;
    end else if (step) begin
      phase <= phase_next;
      cnt   <= cnt_next;
      pos   <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      fin    <= fin_next;
      rsv    <= rsv_next;
      opc    <= opc_next;
      mask   <= mask_next;
      len    <= len_next;
      key    <= key_next;
      remain <= remain_next;
    end
  end

  a_eof_returns_to_header: assert property (@(posedge clk) disable iff (rst)
    step && res_valid && res.end_of_frame |=> phase == PH_HDR0)
    else $error("frame end did not return to header phase");

  a_header_last_iff_empty: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.kind == KIND_HEADER |->
      res.end_of_frame == (res.payload_length == '0))
    else $error("header end flag disagrees with length");

  a_data_phase_remaining: assert property (@(posedge clk) disable iff (rst)
    step && res_valid && res.kind == KIND_HEADER && !res.end_of_frame
      |=> phase == PH_DATA && remain != '0)
    else $error("payload phase entered with nothing remaining");

endmodule

// File: hdl/websocket_frame_deframer.sv
// WebSocket frame deframer top level: input register, parser, result register.
//
//  channel | dir | tdata                          | tuser | tlast
//  s_*     | in  | rx_byte                        | -     | -
//  m_*     | out | fin,rsv,opcode,mask,len,data   | kind  | end_of_frame
//
// One byte per cycle while m_tready is high (m_tready low stalls the input); a
// byte is held in the input register until it advances through the parser,
// and its result is loaded into the result register and offered on m_*.
// Header bytes other than the last produce no result.
// rst is synchronous and clears the parser phase and the valid flags.
// s_tready stays high while the result register is empty or being drained.
module websocket_frame_deframer import wsfd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // [0] final_flag, [3:1] reserved_bits,
                                 // [7:4] frame_opcode, [8] masked,
                                 // [71:9] payload_length, [79:72] data_out
  output logic        m_tuser,   // [0] kind
  output logic        m_tlast    // end_of_frame
);

  logic       in_valid;
  logic [7:0] in_byte;
  logic       advance;
  logic       res_valid;
  result_t    res;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
    end
  end

  wsfd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .rx_byte   (in_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= res_valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {res.data_out, res.payload_length, res.masked,
                  res.frame_opcode, res.reserved_bits, res.final_flag};
      m_tuser <= res.kind;
      m_tlast <= res.end_of_frame;
    end
  end

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty result register");

  a_input_held: assert property (@(posedge clk) disable iff (rst)
    in_valid && !advance |=> in_valid && $stable(in_byte))
    else $error("stalled input byte lost");

  a_input_captured: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> in_valid)
    else $error("accepted byte not registered");

endmodule
